// ----- hw/rtl/ogm_pkg.sv -----
package ogm_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_CELL_SIZE = 2'd0;
    localparam logic [1:0] CFG_MAX_DIST  = 2'd1;

    // Item kinds carried in tuser
    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    // Cell codes
    localparam logic [1:0] CELL_UNKNOWN  = 2'd0;
    localparam logic [1:0] CELL_EMPTY    = 2'd1;
    localparam logic [1:0] CELL_OBSTACLE = 2'd2;

    // Rotation and division unit sizes
    localparam int CORDIC_STEPS = 16;
    localparam int DIV_STEPS    = 18;
    localparam logic [14:0] GAIN_INV_Q15 = 15'd19898;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CORDIC,
        ST_DIV_LOAD,
        ST_DIV,
        ST_MARK_ROBOT,
        ST_MARK_OBS,
        ST_DONE
    } ogm_state_t;

    // Arctangent of 2^-i in 2^24 units per turn
    function automatic logic [22:0] atan_lut(input logic [3:0] i);
        logic [22:0] a;
        begin
            unique case (i)
                4'd0:  a = 23'd2097152;
                4'd1:  a = 23'd1238021;
                4'd2:  a = 23'd654136;
                4'd3:  a = 23'd332050;
                4'd4:  a = 23'd166669;
                4'd5:  a = 23'd83416;
                4'd6:  a = 23'd41718;
                4'd7:  a = 23'd20860;
                4'd8:  a = 23'd10430;
                4'd9:  a = 23'd5215;
                4'd10: a = 23'd2608;
                4'd11: a = 23'd1304;
                4'd12: a = 23'd652;
                4'd13: a = 23'd326;
                4'd14: a = 23'd163;
                default: a = 23'd81;
            endcase
            return a;
        end
    endfunction

endpackage

// ----- hw/rtl/occupancy_grid_marker.sv -----
// Occupancy grid marker.
// Input channel s_*: one item per handshake. tuser is the command (update or
// read), tdata holds pose, heading, range and the cell to read.
// Result channel m_*: one item per input item, held in an output register
// until taken; the block takes the next input while a result still waits.
// Config channel cfg_*: register writes, always ready; writes are to be
// done while idle, which the block itself does not enforce. A read item goes
// through one memory read and the result step. An update item takes 16
// CORDIC rotations, then four roundings by the cell size through one shared
// restoring divider, then two grid writes and the result step.
// The block works on one item at a time; s_tready is low while it is busy.
// After reset a clearing pass writes every cell to unknown, one cell per
// cycle; no item is taken meanwhile. If the receiver stalls, the finished
// result waits in the output register and the next item is held at its
// last step.
module occupancy_grid_marker
    import ogm_pkg::*;
#(
    parameter int GRID_COLUMNS = 64,
    parameter int GRID_ROWS    = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // pos_x[19:0], pos_y[39:20], heading[55:40], range_cm[67:56],
    // read_col[73:68], read_row[79:74]
    input  logic [79:0] s_tdata,
    // cmd
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cell_value[1:0], robot_on_map[2], robot_col[8:3], robot_row[14:9],
    // obstacle_marked[15], obstacle_col[21:16], obstacle_row[27:22], zero
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    localparam int DEPTH = GRID_COLUMNS * GRID_ROWS;
    localparam int AW    = $clog2(DEPTH);

    localparam logic signed [19:0] HALF_COLS = 20'(GRID_COLUMNS / 2);
    localparam logic signed [19:0] HALF_ROWS = 20'(GRID_ROWS / 2);
    localparam logic signed [19:0] NUM_COLS  = 20'(GRID_COLUMNS);
    localparam logic signed [19:0] NUM_ROWS  = 20'(GRID_ROWS);

    ogm_state_t state_reg, state_next;

    logic [7:0]  cell_size_reg;
    logic [11:0] max_dist_reg;

    logic               cmd_reg;
    logic signed [19:0] pos_x_reg, pos_y_reg;
    logic [15:0]        heading_reg;
    logic [11:0]        range_reg;
    logic [5:0]         read_col_reg, read_row_reg;

    logic signed [29:0] cx_reg, cy_reg;
    logic signed [23:0] cz_reg;
    logic [3:0]         ccnt_reg;

    logic [1:0]         dsel_reg;
    logic [4:0]         dcnt_reg;
    logic [7:0]         rem_reg;
    logic [17:0]        quo_reg;
    logic               dneg_reg;
    logic signed [19:0] coord_reg [4];

    logic [AW-1:0]      clr_cnt_reg;

    logic               m_valid_reg;
    logic [31:0]        m_data_reg;
    logic [31:0]        m_data_next;

    logic [1:0]         grid_mem [DEPTH];
    logic [1:0]         rd_data_reg;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [1:0]         mem_wdata;

    logic        accept;
    logic        finish;
    logic [7:0]  cs_eff;
    logic        reading_ok;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cs_eff    = (cell_size_reg == 8'd0) ? 8'd1 : cell_size_reg;
    assign reading_ok = (range_reg != 12'd0) && (range_reg < max_dist_reg);
    assign finish    = (state_reg == ST_DONE) && (!m_valid_reg || m_tready);

    // Quadrant split of the heading; the residual is taken from the new item
    logic [15:0]        h2, h2_in;
    logic signed [23:0] z0;
    assign h2    = heading_reg + 16'h2000;
    assign h2_in = s_tdata[55:40] + 16'h2000;
    assign z0    = 24'(signed'({1'b0, h2_in[13:0]}) - 16'sh2000) <<< 8;

    // CORDIC rotation step
    logic signed [29:0] cxs, cys;
    logic signed [23:0] catan;
    assign cxs   = cx_reg >>> ccnt_reg;
    assign cys   = cy_reg >>> ccnt_reg;
    assign catan = signed'({1'b0, atan_lut(ccnt_reg)});

    // Offset after the quadrant rotation
    logic signed [29:0] dx, dy;
    always_comb begin
        case (h2[15:14])
            2'd0:    begin dx = cx_reg;  dy = cy_reg;  end
            2'd1:    begin dx = -cy_reg; dy = cx_reg;  end
            2'd2:    begin dx = -cx_reg; dy = -cy_reg; end
            default: begin dx = cy_reg;  dy = -cx_reg; end
        endcase
    end

    // Pick the scaled value to round and form the divider numerator
    logic signed [32:0] px, py, dv;
    logic [32:0]        dmag, dsum;
    assign px = {{2{pos_x_reg[19]}}, pos_x_reg, 11'b0};
    assign py = {{2{pos_y_reg[19]}}, pos_y_reg, 11'b0};
    always_comb begin
        case (dsel_reg)
            2'd0:    dv = px;
            2'd1:    dv = py;
            2'd2:    dv = px + 33'(dx);
            default: dv = py + 33'(dy);
        endcase
    end
    assign dmag = dv[32] ? 33'(-dv) : 33'(dv);
    assign dsum = dmag + {11'b0, cs_eff, 14'b0};

    // Restoring divide step
    logic [8:0]         rshift;
    logic               rfit;
    logic [17:0]        qdone;
    logic signed [19:0] idx_val;
    assign rshift  = {rem_reg, quo_reg[17]};
    assign rfit    = rshift >= {1'b0, cs_eff};
    assign qdone   = {quo_reg[16:0], rfit};
    always_comb begin
        idx_val = dneg_reg ? -signed'({2'b0, qdone}) : signed'({2'b0, qdone});
        idx_val = idx_val + (dsel_reg[0] ? HALF_ROWS : HALF_COLS);
    end

    // Bounds of the two computed cells
    logic robot_in, obs_in;
    assign robot_in = !coord_reg[0][19] && (coord_reg[0] < NUM_COLS)
                   && !coord_reg[1][19] && (coord_reg[1] < NUM_ROWS);
    assign obs_in   = reading_ok
                   && !coord_reg[2][19] && (coord_reg[2] < NUM_COLS)
                   && !coord_reg[3][19] && (coord_reg[3] < NUM_ROWS);

    logic [AW-1:0] robot_addr, obs_addr, rd_addr;
    assign robot_addr = AW'(coord_reg[1]) * AW'(GRID_COLUMNS) + AW'(coord_reg[0]);
    assign obs_addr   = AW'(coord_reg[3]) * AW'(GRID_COLUMNS) + AW'(coord_reg[2]);
    assign rd_addr    = AW'(read_row_reg) * AW'(GRID_COLUMNS) + AW'(read_col_reg);

    logic read_in;
    assign read_in = ({5'b0, read_col_reg} < 11'(GRID_COLUMNS))
                  && ({5'b0, read_row_reg} < 11'(GRID_ROWS));

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:      if (clr_cnt_reg == AW'(DEPTH - 1)) state_next = ST_IDLE;
            ST_IDLE:       if (accept) begin
                state_next = (s_tuser == CMD_READ) ? ST_READ : ST_CORDIC;
            end
            ST_READ:       state_next = ST_DONE;
            ST_CORDIC:     if (ccnt_reg == 4'(CORDIC_STEPS - 1)) state_next = ST_DIV_LOAD;
            ST_DIV_LOAD:   state_next = ST_DIV;
            ST_DIV:        if (dcnt_reg == 5'(DIV_STEPS - 1)) begin
                state_next = (dsel_reg == 2'd3) ? ST_MARK_ROBOT : ST_DIV_LOAD;
            end
            ST_MARK_ROBOT: state_next = ST_MARK_OBS;
            ST_MARK_OBS:   state_next = ST_DONE;
            ST_DONE:       if (finish) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Handshake and grid write controls
    always_comb begin
        s_tready  = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = robot_addr;
        mem_wdata = CELL_EMPTY;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg;
                mem_wdata = CELL_UNKNOWN;
            end
            ST_IDLE:       s_tready = 1'b1;
            ST_MARK_ROBOT: mem_we = robot_in;
            ST_MARK_OBS: begin
                mem_we    = obs_in;
                mem_waddr = obs_addr;
                mem_wdata = CELL_OBSTACLE;
            end
            default: ;
        endcase
    end

    // Form the result item
    always_comb begin
        m_data_next = '0;
        if (cmd_reg == CMD_READ) begin
            m_data_next[1:0] = read_in ? rd_data_reg : CELL_UNKNOWN;
        end else begin
            m_data_next[2]     = robot_in;
            m_data_next[8:3]   = robot_in ? coord_reg[0][5:0] : 6'd0;
            m_data_next[14:9]  = robot_in ? coord_reg[1][5:0] : 6'd0;
            m_data_next[15]    = obs_in;
            m_data_next[21:16] = obs_in ? coord_reg[2][5:0] : 6'd0;
            m_data_next[27:22] = obs_in ? coord_reg[3][5:0] : 6'd0;
        end
    end

    // Grid memory
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= grid_mem[rd_addr];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            cell_size_reg <= 8'd10;
            max_dist_reg  <= 12'd200;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == CFG_CELL_SIZE) cell_size_reg <= cfg_data[7:0];
                if (cfg_index == CFG_MAX_DIST)  max_dist_reg  <= cfg_data;
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        // Capture the item and load the rotation unit
        if (accept) begin
            cmd_reg      <= s_tuser;
            pos_x_reg    <= s_tdata[19:0];
            pos_y_reg    <= s_tdata[39:20];
            heading_reg  <= s_tdata[55:40];
            range_reg    <= s_tdata[67:56];
            read_col_reg <= s_tdata[73:68];
            read_row_reg <= s_tdata[79:74];
            ccnt_reg     <= '0;
            dsel_reg     <= '0;
            cx_reg       <= 30'(27'(s_tdata[67:56]) * 27'(GAIN_INV_Q15));
            cy_reg       <= '0;
            cz_reg       <= z0;
        end
        // Rotate one step per cycle
        if (state_reg == ST_CORDIC) begin
            if (!cz_reg[23]) begin
                cx_reg <= cx_reg - cys;
                cy_reg <= cy_reg + cxs;
                cz_reg <= cz_reg - catan;
            end else begin
                cx_reg <= cx_reg + cys;
                cy_reg <= cy_reg - cxs;
                cz_reg <= cz_reg + catan;
            end
            ccnt_reg <= ccnt_reg + 1'b1;
        end
        if (state_reg == ST_DIV_LOAD) begin
            rem_reg  <= '0;
            quo_reg  <= dsum[32:15];
            dneg_reg <= dv[32];
            dcnt_reg <= '0;
        end
        if (state_reg == ST_DIV) begin
            rem_reg  <= rfit ? 8'(rshift - {1'b0, cs_eff}) : rshift[7:0];
            quo_reg  <= qdone;
            dcnt_reg <= dcnt_reg + 1'b1;
            if (dcnt_reg == 5'(DIV_STEPS - 1)) begin
                coord_reg[dsel_reg] <= idx_val;
                dsel_reg <= dsel_reg + 1'b1;
            end
        end
        if (finish) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef SYNTHESIS
    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg != ST_IDLE && state_reg != ST_DONE))
        else $error("grid written outside a marking step");
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_tready)
        else $error("item taken while the previous one is in work");
    a_div_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (dcnt_reg < 5'(DIV_STEPS)))
        else $error("divider step count out of range");
`endif

endmodule
